### rtl/assert_macros.svh
// Assertion helpers. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/rss_pkg.sv
package rss_pkg;

    // Field widths
    localparam int KIND_W       = 3;
    localparam int NOW_W        = 32;
    localparam int SEL_W        = 2;
    localparam int EV_W         = 40;
    localparam int TARGET_W     = 10;
    localparam int ELAPSED_OUT_W = 40;
    localparam int DUR_W        = 32;
    localparam int WORD_W       = 42;
    localparam int COUNT_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 42;
    localparam int NUM_WORDS    = 4;
    localparam int QUOT_W       = 23;
    localparam int PROD_W       = NOW_W + QUOT_W;

    // Parameter defaults
    localparam int MAX_STAGES_DEF   = 4;
    localparam int ELAPSED_BITS_DEF = 40;

    // Arithmetic constants
    localparam logic [TARGET_W-1:0] TARGET_MAX = 10'd1000;
    localparam logic [9:0]          MS_PER_S   = 10'd1000;
    // floor(2^32 / 1000): quotient estimate is exact or one low
    localparam logic [QUOT_W-1:0]   RECIP_MS   = 23'd4294967;

    // Register reset values
    localparam logic                  RST_SEQUENCED      = 1'b1;
    localparam logic [COUNT_W-1:0]    RST_STAGE_COUNT    = 3'd2;
    localparam logic [TARGET_W-1:0]   RST_DEFAULT_TARGET = 10'd900;
    localparam logic [WORD_W-1:0]     RST_WORD_A         = {10'd880, 32'd120};
    localparam logic [WORD_W-1:0]     RST_WORD_B         = {10'd920, 32'd300};
    localparam logic [TARGET_W-1:0]   RST_TARGET         = 10'd900;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK       = 3'd0,
        KIND_START      = 3'd1,
        KIND_CHECKPOINT = 3'd2,
        KIND_RESTORE    = 3'd3,
        KIND_FREEZE     = 3'd4,
        KIND_ABORT      = 3'd5
    } kind_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEQUENCED   = 3'd0,
        CFG_STAGE_COUNT = 3'd1,
        CFG_DEF_TARGET  = 3'd2,
        CFG_WORD_A      = 3'd3,
        CFG_WORD_B      = 3'd4,
        CFG_WORD_C      = 3'd5,
        CFG_WORD_D      = 3'd6
    } cfg_e;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK_BASE,
        OP_DIV_MUL,
        OP_DIV_FIX,
        OP_ACCUM,
        OP_WALK,
        OP_START,
        OP_CHECKPOINT,
        OP_RESTORE,
        OP_FREEZE,
        OP_ABORT
    } op_e;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_TICK_SKIP,
        COND_NO_WALK,
        COND_WALK_END
    } cond_e;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ALWAYS,
        EMIT_ON_FALL
    } emit_e;

    typedef enum logic [3:0] {
        STEP_TICK_BASE,
        STEP_DIV_MUL,
        STEP_DIV_FIX,
        STEP_ACCUM,
        STEP_WALK,
        STEP_START,
        STEP_CHECKPOINT,
        STEP_RESTORE,
        STEP_FREEZE,
        STEP_ABORT,
        STEP_FINAL
    } step_e;

    typedef struct packed {
        op_e   op;
        cond_e cond;
        step_e next;
        step_e jump;
        emit_e emit;
        logic  last;
        logic  done;
    } ucode_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [NOW_W-1:0]        now_ms;
        logic                    run_active;
        logic [SEL_W-1:0]        stage_select;
        logic signed [EV_W-1:0]  elapsed_value;
        logic                    freeze_flag;
    } item_t;

    // Sequencer to datapath
    typedef struct packed {
        logic en;
        op_e  op;
        logic emit_fire;
        logic last;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic tick_skip;
        logic no_walk;
        logic walk_end;
    } flags_t;

    typedef struct packed {
        logic [SEL_W-1:0]         stage;
        logic [TARGET_W-1:0]      target;
        logic [ELAPSED_OUT_W-1:0] elapsed;
        logic                     frozen;
    } result_t;

    // Control store
    function automatic ucode_t ucode_rom(input step_e s);
        ucode_t w;
        w = '{op: OP_NONE, cond: COND_NONE, next: STEP_FINAL, jump: STEP_FINAL,
              emit: EMIT_NONE, last: 1'b0, done: 1'b0};
        unique case (s)
            STEP_TICK_BASE:
                w = '{OP_TICK_BASE, COND_TICK_SKIP, STEP_DIV_MUL, STEP_FINAL,
                      EMIT_NONE, 1'b0, 1'b0};
            STEP_DIV_MUL:
                w = '{OP_DIV_MUL, COND_NONE, STEP_DIV_FIX, STEP_DIV_FIX,
                      EMIT_NONE, 1'b0, 1'b0};
            STEP_DIV_FIX:
                w = '{OP_DIV_FIX, COND_NONE, STEP_ACCUM, STEP_ACCUM,
                      EMIT_NONE, 1'b0, 1'b0};
            STEP_ACCUM:
                w = '{OP_ACCUM, COND_NO_WALK, STEP_WALK, STEP_FINAL,
                      EMIT_NONE, 1'b0, 1'b0};
            STEP_WALK:
                w = '{OP_WALK, COND_WALK_END, STEP_WALK, STEP_FINAL,
                      EMIT_ON_FALL, 1'b0, 1'b0};
            STEP_START:
                w = '{OP_START, COND_NONE, STEP_FINAL, STEP_FINAL,
                      EMIT_ALWAYS, 1'b1, 1'b1};
            STEP_CHECKPOINT:
                w = '{OP_CHECKPOINT, COND_NONE, STEP_FINAL, STEP_FINAL,
                      EMIT_ALWAYS, 1'b1, 1'b1};
            STEP_RESTORE:
                w = '{OP_RESTORE, COND_NONE, STEP_FINAL, STEP_FINAL,
                      EMIT_ALWAYS, 1'b1, 1'b1};
            STEP_FREEZE:
                w = '{OP_FREEZE, COND_NONE, STEP_FINAL, STEP_FINAL,
                      EMIT_ALWAYS, 1'b1, 1'b1};
            STEP_ABORT:
                w = '{OP_ABORT, COND_NONE, STEP_FINAL, STEP_FINAL,
                      EMIT_ALWAYS, 1'b1, 1'b1};
            STEP_FINAL:
                w = '{OP_NONE, COND_NONE, STEP_FINAL, STEP_FINAL,
                      EMIT_ALWAYS, 1'b1, 1'b1};
            default:
                w = '{OP_NONE, COND_NONE, STEP_FINAL, STEP_FINAL,
                      EMIT_ALWAYS, 1'b1, 1'b1};
        endcase
        return w;
    endfunction

    // Program entry per item kind; unknown kinds only report status
    function automatic step_e entry_step(input logic [KIND_W-1:0] kind);
        step_e s;
        s = STEP_FINAL;
        unique case (kind)
            KIND_TICK:       s = STEP_TICK_BASE;
            KIND_START:      s = STEP_START;
            KIND_CHECKPOINT: s = STEP_CHECKPOINT;
            KIND_RESTORE:    s = STEP_RESTORE;
            KIND_FREEZE:     s = STEP_FREEZE;
            KIND_ABORT:      s = STEP_ABORT;
            default:         s = STEP_FINAL;
        endcase
        return s;
    endfunction

endpackage

### rtl/rss_sequencer.sv
module rss_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_fire,
    input  logic [rss_pkg::KIND_W-1:0]   in_kind,
    input  rss_pkg::flags_t              flags,
    input  logic                         out_blocked,
    output rss_pkg::ctrl_t               ctrl,
    output logic                         idle
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_e;

    state_e               state_reg, state_next;
    rss_pkg::step_e       step_reg, step_next;
    rss_pkg::ucode_t      uword;
    logic                 taken;
    logic                 stall;
    logic                 en;

    // Fetch the control word for the current step
    assign uword = rss_pkg::ucode_rom(step_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (uword.cond)
            rss_pkg::COND_NONE:      taken = 1'b0;
            rss_pkg::COND_TICK_SKIP: taken = flags.tick_skip;
            rss_pkg::COND_NO_WALK:   taken = flags.no_walk;
            rss_pkg::COND_WALK_END:  taken = flags.walk_end;
            default:                 taken = 1'b0;
        endcase
    end

    // Hold the step while a result would overwrite an unread one
    assign stall = (uword.emit != rss_pkg::EMIT_NONE) && out_blocked;
    assign en    = (state_reg == ST_RUN) && !stall;

    always_comb
    begin
        ctrl.en        = en;
        ctrl.op        = uword.op;
        ctrl.last      = uword.last;
        ctrl.emit_fire = en && ((uword.emit == rss_pkg::EMIT_ALWAYS) ||
                                ((uword.emit == rss_pkg::EMIT_ON_FALL) && !taken));
    end

    // Advance the step counter
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RUN;
                    step_next  = rss_pkg::entry_step(in_kind);
                end
            end
            ST_RUN:
            begin
                if (en)
                begin
                    if (uword.done)
                        state_next = ST_IDLE;
                    else
                        step_next = taken ? uword.jump : uword.next;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= rss_pkg::STEP_FINAL;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

### rtl/rss_datapath.sv
module rss_datapath #(
    parameter int MAX_STAGES   = rss_pkg::MAX_STAGES_DEF,
    parameter int ELAPSED_BITS = rss_pkg::ELAPSED_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rss_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_fire,
    input  rss_pkg::item_t                  in_item,
    input  rss_pkg::ctrl_t                  ctrl,
    output rss_pkg::flags_t                 flags,
    output rss_pkg::result_t                result
);

    localparam logic [63:0] ELAPSED_MAX64 = (64'd1 << ELAPSED_BITS) - 64'd1;
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = ELAPSED_MAX64[ELAPSED_BITS-1:0];
    localparam logic [rss_pkg::COUNT_W-1:0] MAX_N = rss_pkg::COUNT_W'(MAX_STAGES);

    // Configuration
    logic                                 sequenced_reg;
    logic [rss_pkg::COUNT_W-1:0]          stage_count_reg;
    logic [rss_pkg::TARGET_W-1:0]         default_target_reg;
    logic [rss_pkg::WORD_W-1:0]           word_reg [rss_pkg::NUM_WORDS];

    // Item held for the run of its program
    rss_pkg::item_t                       item_reg;

    // Timer state
    logic [ELAPSED_BITS-1:0]              elapsed_reg, elapsed_next;
    logic [rss_pkg::SEL_W-1:0]            stage_reg, stage_next;
    logic [rss_pkg::TARGET_W-1:0]         target_reg, target_next;
    logic                                 frozen_reg, frozen_next;
    logic [rss_pkg::NOW_W-1:0]            base_reg, base_next;

    // Divider scratch
    logic [rss_pkg::NOW_W-1:0]            dt_reg, dt_next;
    logic [rss_pkg::QUOT_W-1:0]           q0_reg, q0_next;
    logic [rss_pkg::QUOT_W-1:0]           q_reg, q_next;

    logic [rss_pkg::COUNT_W-1:0]          n_use;
    logic [rss_pkg::DUR_W-1:0]            dur;
    logic [ELAPSED_BITS-1:0]              dur_ext;
    logic [rss_pkg::COUNT_W-1:0]          stage_inc;
    logic [rss_pkg::PROD_W-1:0]           prod;
    logic [rss_pkg::NOW_W:0]              rem;
    logic [ELAPSED_BITS:0]                sum;
    logic [ELAPSED_BITS-1:0]              ev_clamped;
    logic [63:0]                          ev_ext;
    logic [63:0]                          elapsed_out64;

    function automatic logic [rss_pkg::TARGET_W-1:0] clamp_target(
        input logic [rss_pkg::TARGET_W-1:0] t
    );
        return (t > rss_pkg::TARGET_MAX) ? rss_pkg::TARGET_MAX : t;
    endfunction

    // Clamp a stage index to those in use and look up its target
    function automatic logic [rss_pkg::SEL_W+rss_pkg::TARGET_W-1:0] apply_stage(
        input logic [rss_pkg::COUNT_W-1:0]  idx,
        input logic [rss_pkg::COUNT_W-1:0]  n,
        input logic                         seq,
        input logic [rss_pkg::TARGET_W-1:0] dflt,
        input logic [rss_pkg::WORD_W-1:0]   w0,
        input logic [rss_pkg::WORD_W-1:0]   w1,
        input logic [rss_pkg::WORD_W-1:0]   w2,
        input logic [rss_pkg::WORD_W-1:0]   w3
    );
        logic [rss_pkg::COUNT_W-1:0]  k;
        logic [rss_pkg::SEL_W-1:0]    s;
        logic [rss_pkg::WORD_W-1:0]   w;
        logic [rss_pkg::TARGET_W-1:0] t;
        k = (idx >= n) ? (n - 3'd1) : idx;
        s = k[rss_pkg::SEL_W-1:0];
        unique case (s)
            2'd0:    w = w0;
            2'd1:    w = w1;
            2'd2:    w = w2;
            default: w = w3;
        endcase
        t = seq ? clamp_target(w[rss_pkg::WORD_W-1:rss_pkg::DUR_W]) : clamp_target(dflt);
        return {s, t};
    endfunction

    // Stages in use
    always_comb
    begin
        priority if (!sequenced_reg)
            n_use = 3'd1;
        else if (stage_count_reg == 3'd0)
            n_use = 3'd1;
        else if (stage_count_reg > MAX_N)
            n_use = MAX_N;
        else
            n_use = stage_count_reg;
    end

    assign dur       = word_reg[stage_reg][rss_pkg::DUR_W-1:0];
    assign dur_ext   = ELAPSED_BITS'(dur);
    assign stage_inc = rss_pkg::COUNT_W'(stage_reg) + 3'd1;

    // Status flags for the jump logic
    always_comb
    begin
        flags.tick_skip = !item_reg.run_active || frozen_reg || (base_reg == '0);
        flags.no_walk   = (q_reg == '0) || !sequenced_reg;
        flags.walk_end  = (elapsed_reg < dur_ext) || (stage_inc >= n_use);
    end

    // Seconds from milliseconds: reciprocal estimate, then one correction
    assign prod = rss_pkg::PROD_W'(dt_reg) * rss_pkg::PROD_W'(rss_pkg::RECIP_MS);
    assign rem  = (rss_pkg::NOW_W+1)'(dt_reg)
                - (rss_pkg::NOW_W+1)'(q0_reg) * (rss_pkg::NOW_W+1)'(rss_pkg::MS_PER_S);
    assign sum  = {1'b0, elapsed_reg} + (ELAPSED_BITS+1)'(q_reg);

    // Checkpoint and restore value: negative reads as zero
    assign ev_ext = {25'd0, item_reg.elapsed_value[rss_pkg::EV_W-2:0]};
    always_comb
    begin
        priority if (item_reg.elapsed_value[rss_pkg::EV_W-1])
            ev_clamped = '0;
        else if (ev_ext > ELAPSED_MAX64)
            ev_clamped = ELAPSED_MAX;
        else
            ev_clamped = ev_ext[ELAPSED_BITS-1:0];
    end

    // Execute the current micro-operation
    always_comb
    begin
        elapsed_next = elapsed_reg;
        stage_next   = stage_reg;
        target_next  = target_reg;
        frozen_next  = frozen_reg;
        base_next    = base_reg;
        dt_next      = dt_reg;
        q0_next      = q0_reg;
        q_next       = q_reg;
        if (ctrl.en)
        begin
            unique case (ctrl.op)
                rss_pkg::OP_NONE:
                begin
                end
                rss_pkg::OP_TICK_BASE:
                begin
                    // Latch on the first counted tick, else measure and rebase
                    if (item_reg.run_active && !frozen_reg)
                    begin
                        dt_next   = item_reg.now_ms - base_reg;
                        base_next = item_reg.now_ms;
                    end
                end
                rss_pkg::OP_DIV_MUL:
                    q0_next = prod[rss_pkg::PROD_W-1:rss_pkg::NOW_W];
                rss_pkg::OP_DIV_FIX:
                    q_next = (rem >= (rss_pkg::NOW_W+1)'(rss_pkg::MS_PER_S))
                           ? q0_reg + 23'd1 : q0_reg;
                rss_pkg::OP_ACCUM:
                begin
                    if (q_reg != '0)
                        elapsed_next = sum[ELAPSED_BITS] ? ELAPSED_MAX
                                                         : sum[ELAPSED_BITS-1:0];
                end
                rss_pkg::OP_WALK:
                begin
                    if (!flags.walk_end)
                    begin
                        elapsed_next = elapsed_reg - dur_ext;
                        {stage_next, target_next} = apply_stage(stage_inc, n_use,
                            sequenced_reg, default_target_reg,
                            word_reg[0], word_reg[1], word_reg[2], word_reg[3]);
                    end
                    else if (elapsed_reg >= dur_ext)
                    begin
                        // Clamp at the last stage
                        elapsed_next = dur_ext;
                    end
                end
                rss_pkg::OP_START:
                begin
                    elapsed_next = '0;
                    frozen_next  = 1'b0;
                    base_next    = item_reg.now_ms;
                    {stage_next, target_next} = apply_stage(3'd0, n_use,
                        sequenced_reg, default_target_reg,
                        word_reg[0], word_reg[1], word_reg[2], word_reg[3]);
                end
                rss_pkg::OP_CHECKPOINT:
                begin
                    elapsed_next = ev_clamped;
                    base_next    = item_reg.now_ms;
                    {stage_next, target_next} = apply_stage(
                        rss_pkg::COUNT_W'(item_reg.stage_select), n_use,
                        sequenced_reg, default_target_reg,
                        word_reg[0], word_reg[1], word_reg[2], word_reg[3]);
                end
                rss_pkg::OP_RESTORE:
                    elapsed_next = ev_clamped;
                rss_pkg::OP_FREEZE:
                begin
                    frozen_next = item_reg.freeze_flag;
                    if (!item_reg.freeze_flag)
                        base_next = item_reg.now_ms;
                end
                rss_pkg::OP_ABORT:
                begin
                    frozen_next = 1'b0;
                    base_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result carries the state as it stands after this step
    assign elapsed_out64 = 64'(elapsed_next);
    always_comb
    begin
        result.stage   = stage_next;
        result.target  = target_next;
        result.elapsed = elapsed_out64[rss_pkg::ELAPSED_OUT_W-1:0];
        result.frozen  = frozen_next;
    end

    // Hold configuration and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sequenced_reg      <= rss_pkg::RST_SEQUENCED;
            stage_count_reg    <= rss_pkg::RST_STAGE_COUNT;
            default_target_reg <= rss_pkg::RST_DEFAULT_TARGET;
            word_reg[0]        <= rss_pkg::RST_WORD_A;
            word_reg[1]        <= rss_pkg::RST_WORD_B;
            word_reg[2]        <= '0;
            word_reg[3]        <= '0;
            elapsed_reg        <= '0;
            stage_reg          <= '0;
            target_reg         <= rss_pkg::RST_TARGET;
            frozen_reg         <= 1'b0;
            base_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rss_pkg::CFG_SEQUENCED:
                        sequenced_reg <= cfg_data[0];
                    rss_pkg::CFG_STAGE_COUNT:
                        stage_count_reg <= cfg_data[rss_pkg::COUNT_W-1:0];
                    rss_pkg::CFG_DEF_TARGET:
                        default_target_reg <= cfg_data[rss_pkg::TARGET_W-1:0];
                    rss_pkg::CFG_WORD_A:
                        word_reg[0] <= cfg_data;
                    rss_pkg::CFG_WORD_B:
                        word_reg[1] <= cfg_data;
                    rss_pkg::CFG_WORD_C:
                        word_reg[2] <= cfg_data;
                    rss_pkg::CFG_WORD_D:
                        word_reg[3] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            elapsed_reg <= elapsed_next;
            stage_reg   <= stage_next;
            target_reg  <= target_next;
            frozen_reg  <= frozen_next;
            base_reg    <= base_next;
        end
    end

    // Payload registers without reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_item;
        dt_reg <= dt_next;
        q0_reg <= q0_next;
        q_reg  <= q_next;
    end

endmodule

### rtl/recipe_stage_sequencer.sv
// Channel  | Direction | Handshake          | Payload
// input    | in        | in_valid/in_ready  | kind, now_ms, run_active, stage_select,
//          |           |                    | elapsed_value, freeze_flag
// result   | out       | out_valid/out_ready| stage_now, target_now, elapsed_now,
//          |           |                    | advanced, frozen_now, last
// config   | in        | cfg_we             | cfg_index, cfg_data
//
// Items run one at a time through the micro-program, one step per cycle; in_ready
// returns the cycle after the final step. Edit kinds and unknown kinds take 1 step,
// a tick that is ignored or only latches the time 2, a counted tick 5 when no whole
// second passed or in free mode, else 6 plus one per stage advance (at most 3).
// A step that may emit waits while the result register holds an unread item.
// Reset (rst_n, asynchronous) restores config, control and timer state at once.
`include "assert_macros.svh"

module recipe_stage_sequencer #(
    parameter int MAX_STAGES   = rss_pkg::MAX_STAGES_DEF,
    parameter int ELAPSED_BITS = rss_pkg::ELAPSED_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                cfg_we,
    input  logic [rss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rss_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rss_pkg::KIND_W-1:0]          kind,
    input  logic [rss_pkg::NOW_W-1:0]           now_ms,
    input  logic                                run_active,
    input  logic [rss_pkg::SEL_W-1:0]           stage_select,
    input  logic signed [rss_pkg::EV_W-1:0]     elapsed_value,
    input  logic                                freeze_flag,
    // Result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rss_pkg::SEL_W-1:0]           stage_now,
    output logic [rss_pkg::TARGET_W-1:0]        target_now,
    output logic [rss_pkg::ELAPSED_OUT_W-1:0]   elapsed_now,
    output logic                                advanced,
    output logic                                frozen_now,
    output logic                                last
);

    rss_pkg::item_t                      in_item;
    rss_pkg::ctrl_t                      ctrl;
    rss_pkg::flags_t                     flags;
    rss_pkg::result_t                    result;
    logic                                in_fire;
    logic                                idle;
    logic                                out_blocked;

    logic                                out_valid_reg;
    logic [rss_pkg::SEL_W-1:0]           stage_out_reg;
    logic [rss_pkg::TARGET_W-1:0]        target_out_reg;
    logic [rss_pkg::ELAPSED_OUT_W-1:0]   elapsed_out_reg;
    logic                                adv_out_reg;
    logic                                frozen_out_reg;
    logic                                last_out_reg;

    assign in_ready    = idle;
    assign in_fire     = in_valid && in_ready;
    assign out_blocked = out_valid_reg && !out_ready;

    always_comb
    begin
        in_item.kind          = kind;
        in_item.now_ms        = now_ms;
        in_item.run_active    = run_active;
        in_item.stage_select  = stage_select;
        in_item.elapsed_value = elapsed_value;
        in_item.freeze_flag   = freeze_flag;
    end

    rss_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_kind     (kind),
        .flags       (flags),
        .out_blocked (out_blocked),
        .ctrl        (ctrl),
        .idle        (idle)
    );

    rss_datapath #(
        .MAX_STAGES   (MAX_STAGES),
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_item   (in_item),
        .ctrl      (ctrl),
        .flags     (flags),
        .result    (result)
    );

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_fire)
        begin
            stage_out_reg   <= result.stage;
            target_out_reg  <= result.target;
            elapsed_out_reg <= result.elapsed;
            adv_out_reg     <= !ctrl.last;
            frozen_out_reg  <= result.frozen;
            last_out_reg    <= ctrl.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign stage_now   = stage_out_reg;
    assign target_now  = target_out_reg;
    assign elapsed_now = elapsed_out_reg;
    assign advanced    = adv_out_reg;
    assign frozen_now  = frozen_out_reg;
    assign last        = last_out_reg;

    // Checks
    `ASSERT_ALWAYS(a_no_overwrite, !(ctrl.emit_fire && out_blocked), "result overwritten before taken")
    `ASSERT_ALWAYS(a_no_emit_idle, !(idle && ctrl.emit_fire), "result emitted while idle")
    `ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "sequencer idle after accept")
    `ASSERT_NEXT(a_idle_after_last, ctrl.emit_fire && ctrl.last, in_ready, "not idle after final result")

endmodule
